// ===== design/set_assoc_cache_lru_tag_store_unit_macros.svh =====
// Assertion macros for the set-associative tag store.
// Used by the top level; no other dependencies.
`ifndef SET_ASSOC_CACHE_LRU_TAG_STORE_UNIT_MACROS_SVH
`define SET_ASSOC_CACHE_LRU_TAG_STORE_UNIT_MACROS_SVH

// Same-cycle implication, disabled in reset.
`define SACLT_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled in reset.
`define SACLT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/saclt_pkg.sv =====
// Shared constants, codes and types of the set-associative tag store.
// No dependencies.
`timescale 1ns / 1ps

package saclt_pkg;

    localparam int MAX_SETS   = 256;
    localparam int MAX_WAYS   = 4;
    localparam int AGE_WIDTH  = 16;

    localparam int ADDR_W     = 32;
    localparam int TAG_W      = 32;
    localparam int FUNC_W     = 3;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 5;
    localparam int LOG2_W     = 5;
    localparam int WAYS_LOG_W = 2;

    // set and way indexes (sizes are powers of two)
    localparam int SET_W = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
    localparam int WAY_W = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;

    // operation codes
    localparam logic [FUNC_W-1:0] FN_PROBE = 3'd0;
    localparam logic [FUNC_W-1:0] FN_TOUCH = 3'd1;
    localparam logic [FUNC_W-1:0] FN_FILL  = 3'd2;
    localparam logic [FUNC_W-1:0] FN_DIRTY = 3'd3;
    localparam logic [FUNC_W-1:0] FN_INVAL = 3'd4;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_BLOCK = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CACHE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WAYS  = 2'd2;

    typedef struct packed {
        logic                 valid;
        logic                 dirty;
        logic [AGE_WIDTH-1:0] age;
        logic [TAG_W-1:0]     tag;
    } way_t;

    typedef way_t [MAX_WAYS-1:0] row_t;

    typedef struct packed {
        logic [FUNC_W-1:0]    func;
        logic [TAG_W-1:0]     tag;
        logic [AGE_WIDTH-1:0] best_age;
    } alu_ctl_t;

    typedef struct packed {
        logic match;
        logic older;
        way_t upd;
    } alu_res_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECODE,
        ST_READ,
        ST_LOAD,
        ST_SCAN,
        ST_RESOLVE,
        ST_WRITE
    } state_t;

endpackage

// ===== design/saclt_ifs.sv =====
// Valid/ready channel interfaces: request, response and config write.
// Depends on saclt_pkg.
`timescale 1ns / 1ps

interface saclt_req_if
    import saclt_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [FUNC_W-1:0] func;
    logic [ADDR_W-1:0] address;

    modport source (output valid, func, address, input ready);
    modport sink   (input valid, func, address, output ready);
endinterface

interface saclt_rsp_if
    import saclt_pkg::*;
;
    logic              valid;
    logic              ready;
    logic              hit;
    logic              victim_valid;
    logic [ADDR_W-1:0] victim_address;
    logic              victim_dirty;

    modport source (output valid, hit, victim_valid, victim_address, victim_dirty,
                    input ready);
    modport sink   (input valid, hit, victim_valid, victim_address, victim_dirty,
                    output ready);
endinterface

interface saclt_cfg_if
    import saclt_pkg::*;
;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ===== design/saclt_row_mem.sv =====
// Set row memory: one row of all ways per set, registered read.
// Per-row valid flops make unwritten rows read as all zero. Depends on saclt_pkg.
`timescale 1ns / 1ps

module saclt_row_mem
    import saclt_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             rd_en,
    input  logic [SET_W-1:0] rd_addr,
    output row_t             rd_row,
    input  logic             wr_en,
    input  logic [SET_W-1:0] wr_addr,
    input  row_t             wr_row
);

    row_t                mem [MAX_SETS];
    row_t                rd_raw_reg;
    logic                rd_vld_reg;
    logic [MAX_SETS-1:0] row_vld_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_row;
        end
        if (rd_en)
        begin
            rd_raw_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_vld_reg <= '0;
            rd_vld_reg  <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                row_vld_reg[wr_addr] <= 1'b1;
            end
            if (rd_en)
            begin
                rd_vld_reg <= row_vld_reg[rd_addr];
            end
        end
    end

    assign rd_row = rd_vld_reg ? rd_raw_reg : '0;

endmodule

// ===== design/saclt_way_alu.sv =====
// Shared per-way unit: tag match, age compare and way update.
// Depends on saclt_pkg.
`timescale 1ns / 1ps

module saclt_way_alu
    import saclt_pkg::*;
(
    input  way_t     cur,
    input  alu_ctl_t ctl,
    output alu_res_t res
);

    localparam logic [AGE_WIDTH-1:0] AGE_MAX = '1;

    logic match;

    assign match = cur.valid && (cur.tag == ctl.tag);

    always_comb
    begin
        res.match = match;
        res.older = cur.age > ctl.best_age;
        res.upd   = cur;
        case (ctl.func)
            FN_TOUCH:
            begin
                if (match)
                begin
                    res.upd.age = '0;
                end
                else if (cur.age != AGE_MAX)
                begin
                    res.upd.age = cur.age + 1'b1;
                end
            end
            FN_DIRTY:
            begin
                if (match)
                begin
                    res.upd.dirty = 1'b1;
                end
            end
            FN_INVAL:
            begin
                if (match)
                begin
                    res.upd.valid = 1'b0;
                    res.upd.dirty = 1'b0;
                    res.upd.age   = '0;
                end
            end
            default:
            begin
                res.upd = cur;
            end
        endcase
    end

endmodule

// ===== design/set_assoc_cache_lru_tag_store_unit.sv =====
// Top level of the set-associative tag store with aging-counter LRU.
// Depends on saclt_pkg, saclt_ifs, saclt_row_mem, saclt_way_alu and the macro header.
`timescale 1ns / 1ps

// One item at a time: a request is taken only when the block is idle, and the
// next one only once the previous one has left its row write-back; the single
// shared way unit sweeps the set row one way per cycle between a registered row
// read and that write-back. Each request gives exactly one response; the
// response sits in an output register, so a stalled response does not hold the
// next request out until it has finished its own sweep. Unwritten sets read as
// empty through one valid flop per set, so there is no clearing pass after
// reset. Config writes are always accepted and must only be issued while no
// request is in flight.

`include "set_assoc_cache_lru_tag_store_unit_macros.svh"

module set_assoc_cache_lru_tag_store_unit
    import saclt_pkg::*;
(
    input logic         clk,
    input logic         rst_n,
    saclt_cfg_if.sink   cfg,
    saclt_req_if.sink   req,
    saclt_rsp_if.source rsp
);

    // config registers
    logic [LOG2_W-1:0]     blk_reg;
    logic [LOG2_W-1:0]     cache_reg;
    logic [WAYS_LOG_W-1:0] wl_reg;

    // control
    state_t            state_reg, state_next;
    logic [WAY_W-1:0]  way_idx_reg;
    logic [WAY_W-1:0]  last_way_reg;
    logic              out_valid_reg;
    logic              out_free;
    logic              accept;
    logic              rd_en, wr_en, out_load;

    // item payload
    logic [FUNC_W-1:0] func_reg;
    logic [ADDR_W-1:0] addr_reg;
    logic [SET_W-1:0]  set_reg;
    logic [TAG_W-1:0]  tag_reg;
    row_t              row_reg;
    row_t              rd_row;

    // sweep results
    logic                 hit_reg;
    logic                 full_reg;
    logic                 free_found_reg;
    logic [WAY_W-1:0]     free_idx_reg;
    logic [WAY_W-1:0]     pick_reg;
    logic [AGE_WIDTH-1:0] best_age_reg;
    logic                 inval_dirty_reg;

    // result staging and output payload
    logic              res_vvalid_reg;
    logic [ADDR_W-1:0] res_vaddr_reg;
    logic              res_vdirty_reg;
    logic              out_hit_reg;
    logic              out_vvalid_reg;
    logic [ADDR_W-1:0] out_vaddr_reg;
    logic              out_vdirty_reg;

    // address split from the current config
    logic [LOG2_W:0]   used_bits;
    logic [LOG2_W-1:0] set_bits;
    logic [LOG2_W:0]   tag_shift;
    logic [ADDR_W-1:0] set_field;
    logic [SET_W-1:0]  set_dec;
    logic [TAG_W-1:0]  tag_dec;
    logic [WAY_W-1:0]  last_way_dec;
    logic [ADDR_W-1:0] rebuilt;

    // shared way unit
    logic [WAY_W-1:0]  sel_way;
    way_t              cur_way;
    alu_ctl_t          alu_ctl;
    alu_res_t          alu_res;

    //--------------------------------------------------------------------
    // Config port
    //--------------------------------------------------------------------
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            blk_reg   <= 5'd2;
            cache_reg <= 5'd10;
            wl_reg    <= 2'd1;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                CFG_BLOCK: blk_reg   <= cfg.data;
                CFG_CACHE: cache_reg <= cfg.data;
                CFG_WAYS:  wl_reg    <= cfg.data[WAYS_LOG_W-1:0];
                default:   ;
            endcase
        end
    end

    //--------------------------------------------------------------------
    // Address decode. Set bits clamp at zero when the cache is too small;
    // a tag shift of 32 or more leaves a zero tag.
    //--------------------------------------------------------------------
    always_comb
    begin
        used_bits = {1'b0, blk_reg} + {{(LOG2_W + 1 - WAYS_LOG_W){1'b0}}, wl_reg};
        set_bits  = ({1'b0, cache_reg} > used_bits)
                  ? LOG2_W'({1'b0, cache_reg} - used_bits) : '0;
        tag_shift = {1'b0, blk_reg} + {1'b0, set_bits};
        set_field = (addr_reg >> blk_reg) & ~({ADDR_W{1'b1}} << set_bits);
        set_dec   = set_field[SET_W-1:0];
        tag_dec   = tag_shift[LOG2_W] ? '0 : TAG_W'(addr_reg >> tag_shift[LOG2_W-1:0]);
        if (int'(wl_reg) >= WAY_W)
        begin
            last_way_dec = WAY_W'(MAX_WAYS - 1);
        end
        else
        begin
            last_way_dec = WAY_W'((1 << wl_reg) - 1);
        end
        // victim address from the selected way's tag and the current set
        rebuilt = ({{(ADDR_W - SET_W){1'b0}}, set_reg} << blk_reg)
                | (tag_shift[LOG2_W] ? '0 : ADDR_W'(cur_way.tag << tag_shift[LOG2_W-1:0]));
    end

    //--------------------------------------------------------------------
    // Sequencer
    //--------------------------------------------------------------------
    assign out_free = !out_valid_reg || rsp.ready;
    assign accept   = req.valid && req.ready;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:    if (req.valid) state_next = ST_DECODE;
            ST_DECODE:  state_next = ST_READ;
            ST_READ:    state_next = ST_LOAD;
            ST_LOAD:    state_next = ST_SCAN;
            ST_SCAN:    if (way_idx_reg == last_way_reg) state_next = ST_RESOLVE;
            ST_RESOLVE: state_next = ST_WRITE;
            ST_WRITE:   if (out_free) state_next = ST_IDLE;
            default:    state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        req.ready = (state_reg == ST_IDLE);
        rd_en     = (state_reg == ST_READ);
        wr_en     = (state_reg == ST_WRITE);
        out_load  = (state_reg == ST_WRITE) && out_free;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            way_idx_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (state_reg == ST_DECODE)
            begin
                way_idx_reg <= '0;
            end
            else if (state_reg == ST_SCAN)
            begin
                way_idx_reg <= way_idx_reg + 1'b1;
            end
        end
    end

    //--------------------------------------------------------------------
    // Row memory and shared way unit
    //--------------------------------------------------------------------
    saclt_row_mem u_mem (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (rd_en),
        .rd_addr (set_reg),
        .rd_row  (rd_row),
        .wr_en   (wr_en),
        .wr_addr (set_reg),
        .wr_row  (row_reg)
    );

    // sweep walks the ways; resolve looks at the way the fill lands in
    assign sel_way = (state_reg == ST_SCAN) ? way_idx_reg
                   : (full_reg ? pick_reg : free_idx_reg);
    assign cur_way = row_reg[sel_way];

    assign alu_ctl.func     = func_reg;
    assign alu_ctl.tag      = tag_reg;
    assign alu_ctl.best_age = best_age_reg;

    saclt_way_alu u_alu (
        .cur (cur_way),
        .ctl (alu_ctl),
        .res (alu_res)
    );

    //--------------------------------------------------------------------
    // Datapath
    //--------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    func_reg <= req.func;
                    addr_reg <= req.address;
                end
            end
            ST_DECODE:
            begin
                set_reg         <= set_dec;
                tag_reg         <= tag_dec;
                last_way_reg    <= last_way_dec;
                hit_reg         <= 1'b0;
                full_reg        <= 1'b1;
                free_found_reg  <= 1'b0;
                free_idx_reg    <= '0;
                pick_reg        <= '0;
                best_age_reg    <= '0;
                inval_dirty_reg <= 1'b0;
            end
            ST_LOAD:
            begin
                row_reg <= rd_row;
            end
            ST_SCAN:
            begin
                // updates depend only on the way's own old contents
                row_reg[sel_way] <= alu_res.upd;
                if (alu_res.match)
                begin
                    hit_reg <= 1'b1;
                end
                if (!cur_way.valid)
                begin
                    full_reg <= 1'b0;
                    if (!free_found_reg)
                    begin
                        free_found_reg <= 1'b1;
                        free_idx_reg   <= way_idx_reg;
                    end
                end
                // first way with the strictly greatest age
                if (alu_res.older)
                begin
                    best_age_reg <= cur_way.age;
                    pick_reg     <= way_idx_reg;
                end
                if (alu_res.match && cur_way.dirty)
                begin
                    inval_dirty_reg <= 1'b1;
                end
            end
            ST_RESOLVE:
            begin
                // a full set evicts the picked way, which then is the first free one
                res_vvalid_reg <= (func_reg == FN_FILL) && full_reg;
                res_vaddr_reg  <= ((func_reg == FN_FILL) && full_reg) ? rebuilt : '0;
                res_vdirty_reg <= (func_reg == FN_FILL) ? (full_reg && cur_way.dirty)
                                : ((func_reg == FN_INVAL) && inval_dirty_reg);
                if (func_reg == FN_FILL)
                begin
                    row_reg[sel_way].valid <= 1'b1;
                    row_reg[sel_way].dirty <= 1'b0;
                    row_reg[sel_way].age   <= '0;
                    row_reg[sel_way].tag   <= tag_reg;
                end
            end
            ST_WRITE:
            begin
                if (out_load)
                begin
                    out_hit_reg    <= hit_reg;
                    out_vvalid_reg <= res_vvalid_reg;
                    out_vaddr_reg  <= res_vaddr_reg;
                    out_vdirty_reg <= res_vdirty_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    assign rsp.valid          = out_valid_reg;
    assign rsp.hit            = out_hit_reg;
    assign rsp.victim_valid   = out_vvalid_reg;
    assign rsp.victim_address = out_vaddr_reg;
    assign rsp.victim_dirty   = out_vdirty_reg;

    //--------------------------------------------------------------------
    // Assertions
    //--------------------------------------------------------------------
    `SACLT_ASSERT_NEXT(a_accept_starts, clk, rst_n, accept, state_reg == ST_DECODE, "request transfer did not start decode")
    `SACLT_ASSERT_IMPL(a_rsp_from_write, clk, rst_n, $rose(out_valid_reg), $past(state_reg == ST_WRITE), "response raised outside write-back")
    `SACLT_ASSERT_IMPL(a_scan_in_range, clk, rst_n, state_reg == ST_SCAN, way_idx_reg <= last_way_reg, "sweep past last way")
    `SACLT_ASSERT_IMPL(a_fill_has_slot, clk, rst_n, (state_reg == ST_RESOLVE) && (func_reg == FN_FILL), full_reg || free_found_reg, "fill found no way")
    `SACLT_ASSERT_NEXT(a_write_holds, clk, rst_n, (state_reg == ST_WRITE) && !out_free, state_reg == ST_WRITE, "write-back left while response stalled")

endmodule

// ===== dv/tb_top.sv =====
// Self-checking testbench for set_assoc_cache_lru_tag_store_unit.
// Holds a tag-store mirror with LRU ages, a directed table and a random access mix
// over many cache geometries. Depends on saclt_pkg, saclt_ifs and the RTL.
`timescale 1ns / 1ps

module tb_top;
    import saclt_pkg::*;

    // Operation codes the block leaves unused; it reports hit and changes nothing.
    localparam logic [FUNC_W-1:0] FN_RSVD_A = 3'd5;
    localparam logic [FUNC_W-1:0] FN_RSVD_B = 3'd6;
    localparam logic [FUNC_W-1:0] FN_RSVD_C = 3'd7;

    localparam int ENTRIES       = MAX_SETS * MAX_WAYS;
    localparam int NUM_DIRECTED  = 25;
    localparam int NUM_GEOM      = 9;
    localparam int ITEMS_PER_GEO = 110;
    localparam int DRAIN_CYCLES  = 16;      // bound on one request's turnaround, with margin
    localparam int STALL_CYCLES  = 300;     // long response hold-off
    localparam int CYCLE_LIMIT   = 400000;

    // One response as the block reports it.
    typedef struct packed {
        logic              hit;
        logic              victim_valid;
        logic [ADDR_W-1:0] victim_address;
        logic              victim_dirty;
    } lookup_t;

    // Directed row: when known is set the typed result is expected, else the mirror's.
    typedef struct packed {
        logic [FUNC_W-1:0] fn;
        logic [ADDR_W-1:0] addr;
        logic              known;
        lookup_t           res;
    } dir_step_t;

    typedef struct packed {
        logic [LOG2_W-1:0]     blk;
        logic [LOG2_W-1:0]     csz;
        logic [WAYS_LOG_W-1:0] wl;
    } geometry_t;

    logic clk = 1'b0;
    logic rst_n;

    saclt_cfg_if cfg_ch ();
    saclt_req_if req_ch ();
    saclt_rsp_if rsp_ch ();

    set_assoc_cache_lru_tag_store_unit dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg_ch),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Mirror of the tag store and of the geometry registers.
    logic                 mirror_valid [ENTRIES];
    logic [TAG_W-1:0]     mirror_tag   [ENTRIES];
    logic [AGE_WIDTH-1:0] mirror_age   [ENTRIES];
    logic                 mirror_dirty [ENTRIES];
    int unsigned          geo_block;
    int unsigned          geo_cache;
    int unsigned          geo_ways;

    lookup_t pending_lookups [$];

    int unsigned mismatches;
    int unsigned sent;
    int unsigned rsp_count;
    int unsigned hits_seen;
    int unsigned evictions_seen;
    int unsigned dirty_victims_seen;
    int unsigned cycle_count;

    logic steady;       // no idling on either side while set
    logic squeeze_go;   // starts the long response hold-off
    logic rsp_hold;

    // Walked in order after reset (block 4 bytes, 128 sets, 2 ways).
    // Addresses of set 127: FFFFFFFF has tag 7FFFFF, 000001FC tag 0,
    // 800001FD tag 400000.
    dir_step_t directed_steps [NUM_DIRECTED] = '{
        '{FN_PROBE,  32'h00000000, 1'b1, '{1'b0, 1'b0, 32'h00000000, 1'b0}},
        '{FN_PROBE,  32'hFFFFFFFF, 1'b1, '{1'b0, 1'b0, 32'h00000000, 1'b0}},
        '{FN_TOUCH,  32'h00000000, 1'b1, '{1'b0, 1'b0, 32'h00000000, 1'b0}},
        '{FN_FILL,   32'hFFFFFFFF, 1'b1, '{1'b0, 1'b0, 32'h00000000, 1'b0}},
        '{FN_PROBE,  32'hFFFFFFFC, 1'b1, '{1'b1, 1'b0, 32'h00000000, 1'b0}},
        '{FN_FILL,   32'h000001FC, 1'b1, '{1'b0, 1'b0, 32'h00000000, 1'b0}},
        '{FN_DIRTY,  32'hFFFFFFFF, 1'b1, '{1'b1, 1'b0, 32'h00000000, 1'b0}},
        '{FN_TOUCH,  32'h000001FC, 1'b1, '{1'b1, 1'b0, 32'h00000000, 1'b0}},
        // set full: the older, dirty way goes out
        '{FN_FILL,   32'h800001FD, 1'b1, '{1'b0, 1'b1, 32'hFFFFFFFC, 1'b1}},
        '{FN_PROBE,  32'hFFFFFFFF, 1'b1, '{1'b0, 1'b0, 32'h00000000, 1'b0}},
        '{FN_INVAL,  32'h800001FD, 1'b1, '{1'b1, 1'b0, 32'h00000000, 1'b0}},
        '{FN_DIRTY,  32'h000001FC, 1'b1, '{1'b1, 1'b0, 32'h00000000, 1'b0}},
        '{FN_INVAL,  32'h000001FE, 1'b1, '{1'b1, 1'b0, 32'h00000000, 1'b1}},
        '{FN_INVAL,  32'h000001FC, 1'b1, '{1'b0, 1'b0, 32'h00000000, 1'b0}},
        '{FN_RSVD_A, 32'h000001FC, 1'b1, '{1'b0, 1'b0, 32'h00000000, 1'b0}},
        '{FN_RSVD_C, 32'hFFFFFFFF, 1'b1, '{1'b0, 1'b0, 32'h00000000, 1'b0}},
        // fill does not look for a hit: same tag lands twice
        '{FN_FILL,   32'h000001FC, 1'b1, '{1'b0, 1'b0, 32'h00000000, 1'b0}},
        '{FN_FILL,   32'h000001FC, 1'b1, '{1'b1, 1'b0, 32'h00000000, 1'b0}},
        // all ages zero: way 0 is the victim
        '{FN_FILL,   32'h000001FC, 1'b1, '{1'b1, 1'b1, 32'h000001FC, 1'b0}},
        '{FN_DIRTY,  32'h000001FC, 1'b0, '0},
        // both copies go, dirty marks OR together
        '{FN_INVAL,  32'h000001FC, 1'b1, '{1'b1, 1'b0, 32'h00000000, 1'b1}},
        '{FN_DIRTY,  32'h00000000, 1'b1, '{1'b0, 1'b0, 32'h00000000, 1'b0}},
        '{FN_FILL,   32'h7FFFFE00, 1'b0, '0},
        '{FN_RSVD_B, 32'h7FFFFE00, 1'b0, '0},
        '{FN_FILL,   32'h80000000, 1'b0, '0}
    };

    // Block, cache and ways log2 per phase: reset values first, then the corners
    // (one way, clamped ways, no set bits, set index wrap, widest fields).
    geometry_t geometries [NUM_GEOM] = '{
        '{5'd2,  5'd10, 2'd1},
        '{5'd0,  5'd2,  2'd0},
        '{5'd4,  5'd8,  2'd2},
        '{5'd16, 5'd26, 2'd2},
        '{5'd0,  5'd26, 2'd0},
        '{5'd3,  5'd4,  2'd3},
        '{5'd31, 5'd31, 2'd3},
        '{5'd0,  5'd0,  2'd0},
        '{5'd5,  5'd20, 2'd1}
    };

    function automatic int unsigned set_bits();
        int unsigned used;
        used = geo_block + geo_ways;
        return (geo_cache > used) ? geo_cache - used : 0;
    endfunction

    // Expected response of one access; updates the mirror the way the block should.
    function automatic lookup_t cache_access(logic [FUNC_W-1:0] fn, logic [ADDR_W-1:0] addr);
        int unsigned          sb, sh, nw, set_idx, base, pick, w;
        logic [63:0]          sel, rebuilt;
        logic [TAG_W-1:0]     tg;
        logic [AGE_WIDTH-1:0] oldest;
        logic                 full, placed;
        lookup_t              res;
        sb      = set_bits();
        sh      = geo_block + sb;
        sel     = ({32'd0, addr} >> geo_block) & ((64'd1 << sb) - 64'd1);
        set_idx = sel[31:0] % MAX_SETS;   // too many sets wrap around
        base    = set_idx * MAX_WAYS;
        tg      = (sh >= 32) ? '0 : addr >> sh;
        nw      = 1 << geo_ways;
        if (nw > MAX_WAYS)
            nw = MAX_WAYS;
        res  = '0;
        full = 1'b1;
        for (w = 0; w < nw; w++)
        begin
            if (mirror_valid[base + w] && mirror_tag[base + w] == tg)
                res.hit = 1'b1;
            if (!mirror_valid[base + w])
                full = 1'b0;
        end
        case (fn)
            FN_TOUCH:
            begin
                // invalid ways age too; counters saturate
                for (w = 0; w < nw; w++)
                begin
                    if (mirror_valid[base + w] && mirror_tag[base + w] == tg)
                        mirror_age[base + w] = '0;
                    else if (mirror_age[base + w] != '1)
                        mirror_age[base + w] = mirror_age[base + w] + 1'b1;
                end
            end
            FN_FILL:
            begin
                if (full)
                begin
                    pick   = 0;
                    oldest = '0;
                    for (w = 0; w < nw; w++)
                    begin
                        if (mirror_age[base + w] > oldest)
                        begin
                            oldest = mirror_age[base + w];
                            pick   = w;
                        end
                    end
                    rebuilt = (64'(set_idx) << geo_block)
                            | ({32'd0, mirror_tag[base + pick]} << sh);
                    res.victim_valid   = 1'b1;
                    res.victim_address = rebuilt[31:0];
                    res.victim_dirty   = mirror_dirty[base + pick];
                    mirror_valid[base + pick] = 1'b0;
                    mirror_dirty[base + pick] = 1'b0;
                    mirror_age[base + pick]   = '0;
                end
                placed = 1'b0;
                for (w = 0; w < nw; w++)
                begin
                    if (!placed && !mirror_valid[base + w])
                    begin
                        mirror_valid[base + w] = 1'b1;
                        mirror_tag[base + w]   = tg;
                        mirror_age[base + w]   = '0;
                        mirror_dirty[base + w] = 1'b0;
                        placed = 1'b1;
                    end
                end
            end
            FN_DIRTY:
            begin
                for (w = 0; w < nw; w++)
                    if (mirror_valid[base + w] && mirror_tag[base + w] == tg)
                        mirror_dirty[base + w] = 1'b1;
            end
            FN_INVAL:
            begin
                for (w = 0; w < nw; w++)
                begin
                    if (mirror_valid[base + w] && mirror_tag[base + w] == tg)
                    begin
                        res.victim_dirty       = res.victim_dirty | mirror_dirty[base + w];
                        mirror_valid[base + w] = 1'b0;
                        mirror_dirty[base + w] = 1'b0;
                        mirror_age[base + w]   = '0;
                    end
                end
            end
            default: ;
        endcase
        return res;
    endfunction

    // Geometric gap: each further idle cycle has a 17 in 100 chance; none while steady.
    function automatic int unsigned idle_gap();
        int unsigned g;
        g = 0;
        if (!steady)
            while ($urandom_range(99) < 17)
                g++;
        return g;
    endfunction

    task automatic flag_mismatch(string what, logic [31:0] want, logic [31:0] got);
        mismatches++;
        if (mismatches <= 100)
            $display("mismatch on response %0d: %s expected %h got %h",
                     rsp_count, what, want, got);
    endtask

    // One request transfer. valid stays high across back-to-back items and only
    // drops when a gap is drawn, so it never gets two assignments in one step.
    task automatic send_access(logic [FUNC_W-1:0] fn, logic [ADDR_W-1:0] addr,
                               logic known, lookup_t typed);
        int unsigned gap;
        lookup_t     model;
        gap = idle_gap();
        if (gap > 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_ch.valid   <= 1'b1;
        req_ch.func    <= fn;
        req_ch.address <= addr;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        // Mirror runs at the transfer; its response cannot show up before next edge.
        model = cache_access(fn, addr);
        pending_lookups.push_back(known ? typed : model);
        sent++;
    endtask

    // One config transfer; valid is handled by the caller.
    task automatic put_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        cfg_ch.index <= idx;
        cfg_ch.data  <= val;
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
    endtask

    // Wait for every expected response, then let the block's sweep settle.
    task automatic settle();
        while (pending_lookups.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Response side: random back-pressure, plus the long hold-off when asked.
    always @(posedge clk)
    begin
        rsp_ch.ready <= !rsp_hold && (steady || $urandom_range(99) >= 17);
    end

    initial
    begin
        rsp_hold = 1'b0;
        while (squeeze_go !== 1'b1)
            @(posedge clk);
        rsp_hold <= 1'b1;
        repeat (STALL_CYCLES) @(posedge clk);
        rsp_hold <= 1'b0;
    end

    // Response checker: values sampled at the edge, before anything updates.
    always @(posedge clk)
    begin
        lookup_t want;
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            if (pending_lookups.size() == 0)
                flag_mismatch("response with nothing outstanding", '0, '0);
            else
            begin
                want = pending_lookups.pop_front();
                if (rsp_ch.hit !== want.hit)
                    flag_mismatch("hit", want.hit, rsp_ch.hit);
                if (rsp_ch.victim_valid !== want.victim_valid)
                    flag_mismatch("victim_valid", want.victim_valid, rsp_ch.victim_valid);
                if (rsp_ch.victim_address !== want.victim_address)
                    flag_mismatch("victim_address", want.victim_address,
                                  rsp_ch.victim_address);
                if (rsp_ch.victim_dirty !== want.victim_dirty)
                    flag_mismatch("victim_dirty", want.victim_dirty, rsp_ch.victim_dirty);
                hits_seen          += want.hit;
                evictions_seen     += want.victim_valid;
                dirty_victims_seen += want.victim_valid & want.victim_dirty;
            end
            rsp_count++;
        end
    end

    // Watchdog.
    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("timeout after %0d cycles, %0d responses outstanding",
                 cycle_count, pending_lookups.size());
        $display("TB_ERROR");
        $finish;
    end

    initial
    begin
        int unsigned       p, k, sb, sh;
        logic [63:0]       a64;
        logic [FUNC_W-1:0] fn;
        logic [ADDR_W-1:0] addr;
        logic [TAG_W-1:0]  tag_pool [6];
        logic [31:0]       set_pool [3];
        geometry_t         g;

        rst_n          = 1'b0;
        req_ch.valid   = 1'b0;
        req_ch.func    = FN_PROBE;
        req_ch.address = '0;
        cfg_ch.valid   = 1'b0;
        cfg_ch.index   = CFG_BLOCK;
        cfg_ch.data    = '0;
        steady         = 1'b0;
        squeeze_go     = 1'b0;
        mismatches     = 0;
        sent           = 0;
        rsp_count      = 0;
        hits_seen      = 0;
        evictions_seen = 0;
        dirty_victims_seen = 0;
        geo_block = 2;
        geo_cache = 10;
        geo_ways  = 1;
        for (k = 0; k < ENTRIES; k++)
        begin
            mirror_valid[k] = 1'b0;
            mirror_tag[k]   = '0;
            mirror_age[k]   = '0;
            mirror_dirty[k] = 1'b0;
        end

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table on the reset geometry.
        for (k = 0; k < NUM_DIRECTED; k++)
            send_access(directed_steps[k].fn, directed_steps[k].addr,
                        directed_steps[k].known, directed_steps[k].res);
        req_ch.valid <= 1'b0;

        // Random phases, one geometry each. Stored blocks survive a geometry
        // change and get reinterpreted; the mirror does the same.
        for (p = 0; p < NUM_GEOM; p++)
        begin
            settle();
            g = geometries[p];
            cfg_ch.valid <= 1'b1;
            put_reg(CFG_BLOCK, g.blk);
            put_reg(CFG_CACHE, g.csz);
            put_reg(CFG_WAYS, {3'b000, g.wl});
            cfg_ch.valid <= 1'b0;
            geo_block = 32'(g.blk);
            geo_cache = 32'(g.csz);
            geo_ways  = 32'(g.wl);

            // Few sets and tags per phase, so sets fill up, hit and evict.
            for (k = 0; k < 6; k++)
                tag_pool[k] = $urandom();
            for (k = 0; k < 3; k++)
                set_pool[k] = $urandom();

            if (p == 3)
                steady <= 1'b1;

            for (k = 0; k < ITEMS_PER_GEO; k++)
            begin
                // Hold responses off for a while but keep offering requests.
                if (p == 2 && k == 10)
                    squeeze_go <= 1'b1;

                case ($urandom_range(19))
                    0, 1, 2:              fn = FN_PROBE;
                    3, 4, 5, 6, 7:        fn = FN_TOUCH;
                    8, 9, 10, 11, 12, 13: fn = FN_FILL;
                    14, 15:               fn = FN_DIRTY;
                    16, 17, 18:           fn = FN_INVAL;
                    default:              fn = FUNC_W'($urandom_range(FN_RSVD_C, FN_RSVD_A));
                endcase

                if ($urandom_range(99) < 20)
                    addr = $urandom();
                else
                begin
                    sb  = set_bits();
                    sh  = geo_block + sb;
                    a64 = ({32'd0, $urandom()} & ((64'd1 << geo_block) - 64'd1))
                        | (({32'd0, set_pool[$urandom_range(2)]}
                            & ((64'd1 << sb) - 64'd1)) << geo_block)
                        | ({32'd0, tag_pool[$urandom_range(5)]} << sh);
                    addr = a64[31:0];
                end
                send_access(fn, addr, 1'b0, '0);
            end
            req_ch.valid <= 1'b0;
            if (p == 3)
                steady <= 1'b0;
        end

        settle();

        $display("covered %0d request transfers over %0d geometries, %0d responses checked",
                 sent, NUM_GEOM, rsp_count);
        $display("saw %0d hits and %0d evictions, %0d of them dirty",
                 hits_seen, evictions_seen, dirty_victims_seen);
        if (mismatches == 0 && pending_lookups.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+design
design/saclt_pkg.sv
design/saclt_ifs.sv
design/saclt_row_mem.sv
design/saclt_way_alu.sv
design/set_assoc_cache_lru_tag_store_unit.sv
dv/tb_top.sv
